// ----- src/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants, codes and helpers for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // Sizes of the managed page space and the bitmap
    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int MAP_WORDS  = NUM_PAGES / WORD_W;
    localparam int WIDX_W     = $clog2(MAP_WORDS);
    localparam int PAGE_W     = $clog2(NUM_PAGES);

    // Field widths
    localparam int CNT_W       = 16;
    localparam int ADDR_W      = 27;
    localparam int IN_ADDR_W   = 32;
    localparam int IN_PAGE_W   = 20;
    localparam int FREE_PAGE_W = IN_ADDR_W - PAGE_SHIFT;

    localparam logic [WORD_W-1:0] FULL_WORD = {WORD_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  CAPACITY  = CNT_W'(NUM_PAGES);

    // Configuration register indexes
    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_TEST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // Bitmap RAM request
    typedef struct packed {
        logic                we;
        logic [WIDX_W-1:0]   waddr;
        logic [WORD_W-1:0]   wdata;
        logic [WIDX_W-1:0]   raddr;
    } ram_req_t;

    // First-free search result
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } find_t;

    // Ones in the low n bits of a word
    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] n);
        return (WORD_W'(1) << n) - WORD_W'(1);
    endfunction

    // Bits of word widx whose page number lies below limit
    function automatic logic [WORD_W-1:0] below_mask(input logic [WIDX_W-1:0] widx,
                                                     input logic [CNT_W-1:0]  limit);
        logic [CNT_W-BIT_W-1:0] full_words;
        logic [CNT_W-BIT_W-1:0] idx_ext;
        full_words = limit[CNT_W-1:BIT_W];
        idx_ext    = (CNT_W-BIT_W)'(widx);
        if (idx_ext < full_words)
            return FULL_WORD;
        else if (idx_ext == full_words)
            return low_mask(limit[BIT_W-1:0]);
        else
            return '0;
    endfunction

endpackage

// ----- src/page_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_allocator_top
// First-fit page frame allocator over a bitmap RAM with a used-page count.
// ----------------------------------------------------------------------------
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------------
//  command   | start, busy (taken: start&!busy)| mode, free_address, page_number
//  result    | done (one-cycle strobe)        | status, page_address, page_used,
//            |                                | used_count, free_count
//  config    | cfg_valid, cfg_ready           | cfg_index, cfg_data
//
//  Init sweeps all 1024 bitmap words before it reports the result.
//  Alloc streams one word per cycle through the RAM read port and stops at
//  the first word with a free page, or at the last word when none is free;
//  with a total of zero it reports no free page without a scan. Free and
//  test read and check one word, and answer without a RAM read when rejected
//  on the address or page number alone.
//  Reset: the bitmap is cleared by a sweep of all words with busy high.
//  The result side cannot stall; cfg_ready is low while busy.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // command
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [pba_pkg::IN_ADDR_W-1:0]  free_address,
    input  logic [pba_pkg::IN_PAGE_W-1:0]  page_number,
    // result
    output logic                           done,
    output logic [1:0]                     status,
    output logic [pba_pkg::ADDR_W-1:0]     page_address,
    output logic                           page_used,
    output logic [pba_pkg::CNT_W-1:0]      used_count,
    output logic [pba_pkg::CNT_W-1:0]      free_count,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [pba_pkg::CNT_W-1:0]      cfg_data
);
    import pba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t              state_reg,     state_next;
    logic [CNT_W-1:0]    total_reg,     total_next;
    logic [CNT_W-1:0]    reserved_reg,  reserved_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [CNT_W-1:0]    fill_reg,      fill_next;
    logic                report_reg,    report_next;
    logic [WIDX_W-1:0]   sweep_reg,     sweep_next;
    logic [WIDX_W-1:0]   scan_reg,      scan_next;
    logic [WIDX_W-1:0]   chk_addr_reg,  chk_addr_next;
    logic [BIT_W-1:0]    bit_reg,       bit_next;
    mode_t               op_reg,        op_next;
    logic                done_reg,      done_next;
    status_t             status_reg,    status_next;
    logic [ADDR_W-1:0]   paddr_reg,     paddr_next;
    logic                pused_reg,     pused_next;
    logic [CNT_W-1:0]    used_out_reg,  used_out_next;
    logic [CNT_W-1:0]    free_out_reg,  free_out_next;

    ram_req_t            ram_req;
    logic [WORD_W-1:0]   rd_data;
    find_t               find;

    logic [CNT_W-1:0]    eff_total;
    logic [CNT_W-1:0]    clamp_reserved;
    logic [CNT_W-BIT_W:0] word_count;
    logic [WIDX_W-1:0]   last_word;
    logic [FREE_PAGE_W-1:0] free_page;
    logic                cur_bit;
    logic                finish;

    // Effective total, reserved clamp and last word of the scan
    assign eff_total      = (total_reg > CAPACITY) ? CAPACITY : total_reg;
    assign clamp_reserved = (reserved_reg < eff_total) ? reserved_reg : eff_total;
    assign word_count     = (CNT_W-BIT_W+1)'(({1'b0, eff_total} + (CNT_W+1)'(WORD_W - 1))
                            >> BIT_W);
    assign last_word      = WIDX_W'(word_count - (CNT_W-BIT_W+1)'(1));
    assign free_page      = free_address[IN_ADDR_W-1:PAGE_SHIFT];
    assign cur_bit        = rd_data[bit_reg];

    pba_bitmap_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    pba_find_free u_find (
        .word     (rd_data),
        .word_idx (chk_addr_reg),
        .total    (eff_total),
        .result   (find)
    );

    // Control and datapath next state
    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        reserved_next = reserved_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        report_next   = report_reg;
        sweep_next    = sweep_reg;
        scan_next     = scan_reg;
        chk_addr_next = chk_addr_reg;
        bit_next      = bit_reg;
        op_next       = op_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        paddr_next    = paddr_reg;
        pused_next    = pused_reg;
        used_out_next = used_out_reg;
        free_out_next = free_out_reg;
        ram_req       = '0;
        finish        = 1'b0;

        // result defaults for a completing transaction
        if (state_reg == S_IDLE)
        begin
            status_next = ST_DONE;
            paddr_next  = '0;
            pused_next  = 1'b0;
        end

        // configuration writes, only taken while idle
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TOTAL)
                total_next = cfg_data;
            else
                reserved_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = mode_t'(mode);
                    unique case (mode_t'(mode))
                        MODE_INIT:
                        begin
                            fill_next   = clamp_reserved;
                            report_next = 1'b1;
                            sweep_next  = '0;
                            state_next  = S_SWEEP;
                        end
                        MODE_ALLOC:
                        begin
                            if (eff_total == '0)
                            begin
                                status_next = ST_NO_FREE;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                ram_req.raddr = '0;
                                scan_next     = WIDX_W'(1);
                                chk_addr_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (free_address == '0 ||
                                free_page >= FREE_PAGE_W'(eff_total))
                            begin
                                status_next = ST_IGNORED;
                                finish      = 1'b1;
                            end
                            else
                            begin
                                ram_req.raddr = free_page[BIT_W +: WIDX_W];
                                chk_addr_next = free_page[BIT_W +: WIDX_W];
                                bit_next      = free_page[BIT_W-1:0];
                                state_next    = S_CHECK;
                            end
                        end
                        MODE_TEST:
                        begin
                            if (page_number >= IN_PAGE_W'(eff_total))
                            begin
                                pused_next = 1'b1;
                                finish     = 1'b1;
                            end
                            else
                            begin
                                ram_req.raddr = page_number[BIT_W +: WIDX_W];
                                chk_addr_next = page_number[BIT_W +: WIDX_W];
                                bit_next      = page_number[BIT_W-1:0];
                                state_next    = S_CHECK;
                            end
                        end
                    endcase
                end
            end

            // Rewrite every word: full below the fill mark, partial at it
            S_SWEEP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_reg;
                ram_req.wdata = below_mask(sweep_reg, fill_reg);
                sweep_next    = sweep_reg + WIDX_W'(1);
                if (sweep_reg == WIDX_W'(MAP_WORDS - 1))
                begin
                    count_next = fill_reg;
                    finish     = report_reg;
                    state_next = S_IDLE;
                end
            end

            // One word read per cycle; data returns for chk_addr_reg
            S_SCAN:
            begin
                ram_req.raddr = scan_reg;
                scan_next     = scan_reg + WIDX_W'(1);
                chk_addr_next = scan_reg;
                if (find.hit)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = chk_addr_reg;
                    ram_req.wdata = rd_data | (WORD_W'(1) << find.bit_idx);
                    if (count_reg < CNT_MAX)
                        count_next = count_reg + CNT_W'(1);
                    paddr_next = ADDR_W'({chk_addr_reg, find.bit_idx}) << PAGE_SHIFT;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (chk_addr_reg == last_word)
                begin
                    status_next = ST_NO_FREE;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // Single word read-modify-write for free, single word read for test
            S_CHECK:
            begin
                if (op_reg == MODE_FREE)
                begin
                    if (!cur_bit)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = chk_addr_reg;
                        ram_req.wdata = rd_data & ~(WORD_W'(1) << bit_reg);
                        if (count_reg != '0)
                            count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    pused_next = cur_bit;
                end
                finish     = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result registers
        if (finish)
        begin
            done_next     = 1'b1;
            used_out_next = count_next;
            free_out_next = (eff_total > count_next) ? (eff_total - count_next) : '0;
        end
    end

    // Control registers; reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            total_reg    <= CAPACITY;
            reserved_reg <= CNT_W'(256);
            count_reg    <= '0;
            fill_reg     <= '0;
            report_reg   <= 1'b0;
            sweep_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            reserved_reg <= reserved_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            report_reg   <= report_next;
            sweep_reg    <= sweep_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        bit_reg      <= bit_next;
        op_reg       <= op_next;
        status_reg   <= status_next;
        paddr_reg    <= paddr_next;
        pused_reg    <= pused_next;
        used_out_reg <= used_out_next;
        free_out_reg <= free_out_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign page_address = paddr_reg;
    assign page_used    = pused_reg;
    assign used_count   = used_out_reg;
    assign free_count   = free_out_reg;

`ifndef SYNTHESIS
    // A result only follows a busy cycle or a command taken while idle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without preceding work");

    // Bitmap is never written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg != S_IDLE))
        else $error("bitmap write while idle");

    // The scan never looks past the last word of the managed range
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (chk_addr_reg <= last_word))
        else $error("scan beyond last word");

    // At the end of init the reported used count does not exceed the total
    a_init_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg == S_SWEEP)) |-> (used_count <= eff_total))
        else $error("init count above total");

    // A failed allocation reports no address
    a_no_free_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NO_FREE) |-> (page_address == '0))
        else $error("address on failed allocation");
`endif

endmodule

// ----- src/pba_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// pba_bitmap_ram
// Usage bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pba_bitmap_ram (
    input  logic                      clk,
    input  pba_pkg::ram_req_t         req,
    output logic [pba_pkg::WORD_W-1:0] rd_data
);
    import pba_pkg::*;

    logic [WORD_W-1:0] mem [MAP_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    // Write and synchronous read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/pba_find_free.sv -----
// ----------------------------------------------------------------------------
// pba_find_free
// Lowest free page of one bitmap word, limited to pages below the total.
// ----------------------------------------------------------------------------
module pba_find_free (
    input  logic [pba_pkg::WORD_W-1:0] word,
    input  logic [pba_pkg::WIDX_W-1:0] word_idx,
    input  logic [pba_pkg::CNT_W-1:0]  total,
    output pba_pkg::find_t             result
);
    import pba_pkg::*;

    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] lowest;
    logic [BIT_W-1:0]  idx;

    // Free bits inside the managed range, isolate the lowest
    assign free_bits = ~word & below_mask(word_idx, total);
    assign lowest    = free_bits & (~free_bits + WORD_W'(1));

    // Encode the one-hot lowest bit
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lowest[i])
                idx = idx | BIT_W'(i);
        end
    end

    assign result.hit     = |free_bits;
    assign result.bit_idx = idx;

endmodule
